/* hw/rtl/plti_pkg.sv */
// Package for the lidar point to image projection block.
// Holds payload structs, register indexes, widths and reset defaults; depends on nothing.
package plti_pkg;

  localparam int unsigned ROW_W = 52;   // floored Q36.16 row sum width
  localparam int unsigned QUO_W = 33;   // quotient bits kept before saturation

  localparam logic [2:0] REG_R0_C01 = 3'd0;
  localparam logic [2:0] REG_R0_C23 = 3'd1;
  localparam logic [2:0] REG_R1_C01 = 3'd2;
  localparam logic [2:0] REG_R1_C23 = 3'd3;
  localparam logic [2:0] REG_R2_C01 = 3'd4;
  localparam logic [2:0] REG_R2_C23 = 3'd5;
  localparam logic [2:0] REG_WIDTH  = 3'd6;
  localparam logic [2:0] REG_HEIGHT = 3'd7;

  localparam logic [15:0] RESET_WIDTH  = 16'd1600;
  localparam logic [15:0] RESET_HEIGHT = 16'd900;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] pixel_x;
    logic signed [31:0] pixel_y;
    logic signed [31:0] depth;
    logic               inside_frame;
    logic               divide_fault;
  } out_word_t;

endpackage

/* hw/rtl/plti_div.sv */
// Pipelined restoring divider: one quotient bit per stage, magnitudes in.
// Depends on plti_pkg for the operand and quotient widths.
module plti_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [plti_pkg::ROW_W+15:0]   in_num,   // |num| << 16
  input  logic [plti_pkg::ROW_W-1:0]    in_den,
  output logic                          out_valid,
  output logic [plti_pkg::QUO_W-1:0]    out_quo,  // quotient magnitude; out_big flags overflow
  output logic                          out_big
);
  localparam int unsigned NW = plti_pkg::ROW_W + 16;
  localparam int unsigned QW = plti_pkg::QUO_W;

  // Stage s decides quotient bit QW-1-s; a set bit above that is overflow.
  logic [NW-1:0] rem_r [QW+1];
  logic [plti_pkg::ROW_W-1:0] den_r [QW+1];
  logic [QW-1:0] quo_r [QW+1];
  logic          big_r [QW+1];
  logic          vld_r [QW+1];

  always_comb begin
    rem_r[0] = in_num;
    den_r[0] = in_den;
    quo_r[0] = '0;
    vld_r[0] = in_valid;
    // quotient >= 2^QW iff num >= den << QW
    big_r[0] = ({{QW{1'b0}}, in_num} >=
                ({{(NW+QW-plti_pkg::ROW_W){1'b0}}, in_den} << QW));
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int unsigned SH = QW - 1 - s;
    logic [NW+QW-1:0] dsh;
    logic             take;
    assign dsh  = {{(NW+QW-plti_pkg::ROW_W){1'b0}}, den_r[s]} << SH;
    assign take = ({{QW{1'b0}}, rem_r[s]} >= dsh);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else begin
        vld_r[s+1] <= vld_r[s];
      end
      rem_r[s+1] <= take ? NW'({{QW{1'b0}}, rem_r[s]} - dsh) : rem_r[s];
      den_r[s+1] <= den_r[s];
      big_r[s+1] <= big_r[s];
      quo_r[s+1] <= quo_r[s] | (QW'(take) << SH);
    end
  end

  assign out_valid = vld_r[QW];
  assign out_quo   = quo_r[QW];
  assign out_big   = big_r[QW];
endmodule

/* hw/rtl/project_lidar_point_to_image.sv */
// Lidar point to image projection: 3x4 matrix, then u/w and v/w.
// Throughput one word per cycle; the pipeline never stalls.
// The 33-stage divider sits between 3 product, sum and sign stages and 2 output stages.
// Synchronous active-low reset clears valids and reloads the register defaults.
// Results are strobed for one cycle; the receiver cannot stall.
module project_lidar_point_to_image (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  plti_pkg::in_word_t  in_word,
  output logic                out_valid,
  output plti_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data
);
  localparam int unsigned RW = plti_pkg::ROW_W;
  localparam int unsigned QW = plti_pkg::QUO_W;
  localparam int unsigned LAT = QW + 5;

  // The pipeline never stalls, so a new word is taken in every cycle.
  assign busy = 1'b0;

  // Configuration registers.
  logic [63:0] coef_r [6];
  logic [15:0] width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) coef_r[i] <= '0;
      width_r  <= plti_pkg::RESET_WIDTH;
      height_r <= plti_pkg::RESET_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        plti_pkg::REG_WIDTH:  width_r  <= cfg_data[15:0];
        plti_pkg::REG_HEIGHT: height_r <= cfg_data[15:0];
        default:              coef_r[cfg_index] <= cfg_data;
      endcase
    end
  end

  // Stage 1: nine 32x32 products, registered.
  logic               v1_r;
  logic signed [63:0] prod_r [3][3];
  logic signed [31:0] c3_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= start;
    for (int r = 0; r < 3; r++) begin
      prod_r[r][0] <= $signed(coef_r[2*r][31:0])    * in_word.point_x;
      prod_r[r][1] <= $signed(coef_r[2*r][63:32])   * in_word.point_y;
      prod_r[r][2] <= $signed(coef_r[2*r+1][31:0])  * in_word.point_z;
      c3_r[r]      <= $signed(coef_r[2*r+1][63:32]);
    end
  end

  // Stage 2: Q32.32 sum, floored by dropping the 16 lowest bits.
  logic               v2_r;
  logic signed [RW-1:0] row_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    for (int r = 0; r < 3; r++) begin
      row_r[r] <= RW'((67'(prod_r[r][0]) + 67'(prod_r[r][1]) + 67'(prod_r[r][2])
                      + (67'(c3_r[r]) <<< 16)) >>> 16);
    end
  end

  // Stage 3: magnitudes and signs for the two divisions.
  logic          v3_r;
  logic [RW-1:0] mu_r, mv_r, mw_r;
  logic          nu_r, nv_r, wz_r;
  logic signed [31:0] dep_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
    mu_r  <= row_r[0][RW-1] ? RW'(-row_r[0]) : row_r[0];
    mv_r  <= row_r[1][RW-1] ? RW'(-row_r[1]) : row_r[1];
    mw_r  <= row_r[2][RW-1] ? RW'(-row_r[2]) : row_r[2];
    nu_r  <= row_r[0][RW-1] ^ row_r[2][RW-1];
    nv_r  <= row_r[1][RW-1] ^ row_r[2][RW-1];
    wz_r  <= (row_r[2] == '0);
    dep_r <= (row_r[2] > RW'(64'sh7FFF_FFFF))   ? 32'sh7FFF_FFFF :
             (row_r[2] < -RW'(64'sh8000_0000)) ? 32'sh8000_0000 : row_r[2][31:0];
  end

  // Dividers; a zero divisor is replaced by one, the fault masks the result.
  logic          dxv, dyv, bx, by;
  logic [QW-1:0] qx, qy;
  logic [RW-1:0] den;
  assign den = wz_r ? RW'(1) : mw_r;

  plti_div u_div_x (.clk, .rst_n, .in_valid(v3_r), .in_num({mu_r, 16'h0}),
                    .in_den(den), .out_valid(dxv), .out_quo(qx), .out_big(bx));
  plti_div u_div_y (.clk, .rst_n, .in_valid(v3_r), .in_num({mv_r, 16'h0}),
                    .in_den(den), .out_valid(dyv), .out_quo(qy), .out_big(by));

  // Side information delayed alongside the divider stages.
  logic [QW-1:0] dnx_r, dny_r, dwz_r;
  logic signed [31:0] ddep_r [QW];
  always_ff @(posedge clk) begin
    dnx_r <= {dnx_r[QW-2:0], nu_r};
    dny_r <= {dny_r[QW-2:0], nv_r};
    dwz_r <= {dwz_r[QW-2:0], wz_r};
    ddep_r[0] <= dep_r;
    for (int i = 1; i < QW; i++) ddep_r[i] <= ddep_r[i-1];
  end

  function automatic logic signed [31:0] sat_sign(logic [QW-1:0] q, logic big, logic neg);
    if (neg) return (big || q >= QW'(33'h8000_0000)) ? 32'sh8000_0000 : -$signed(q[31:0]);
    return (big || q > QW'(33'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
  endfunction

  // Stage 4: sign, saturation and fault masking.
  logic               v4_r, f4_r;
  logic signed [31:0] sx_r, sy_r, d4_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= dxv;
    f4_r <= dwz_r[QW-1];
    d4_r <= ddep_r[QW-1];
    sx_r <= dwz_r[QW-1] ? 32'sd0 : sat_sign(qx, bx, dnx_r[QW-1]);
    sy_r <= dwz_r[QW-1] ? 32'sd0 : sat_sign(qy, by, dny_r[QW-1]);
  end

  // Stage 5: frame test and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= v4_r;
    out_word.pixel_x      <= sx_r;
    out_word.pixel_y      <= sy_r;
    out_word.depth        <= d4_r;
    out_word.divide_fault <= f4_r;
    out_word.inside_frame <= !f4_r && sx_r > 0 && sy_r > 0 &&
                             48'(sx_r) < $signed({16'h0, width_r, 16'h0}) &&
                             48'(sy_r) < $signed({16'h0, height_r, 16'h0});
  end

  // The two dividers run in lockstep.
  a_lockstep: assert property (@(posedge clk) disable iff (!rst_n) dxv == dyv)
    else $error("divider valids differ");
  // A fault result never claims to be inside the frame.
  a_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.divide_fault |-> !out_word.inside_frame)
    else $error("inside flag with fault");
  // Every word taken appears after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(start, LAT) && $past(rst_n, LAT) |-> out_valid)
    else $error("result lost");
  // A fault result carries zero pixel fields.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.divide_fault |-> out_word.pixel_x == 0 && out_word.pixel_y == 0)
    else $error("pixel nonzero on fault");
endmodule
